>>> rtl/stk_pkg.sv
// Shared types and constants for the STK500 flash programming engine.
`default_nettype none
package stk_pkg;
  localparam int PageBytesDefault = 256;

  localparam logic [7:0] ST_OK     = 8'h10;
  localparam logic [7:0] ST_FAILED = 8'h11;
  localparam logic [7:0] ST_INSYNC = 8'h14;
  localparam logic [7:0] ST_EOP    = 8'h20;
  localparam logic [7:0] CMD_GET_PARAM   = 8'h41;
  localparam logic [7:0] CMD_SET_DEV     = 8'h42;
  localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
  localparam logic [7:0] CMD_LEAVE       = 8'h51;
  localparam logic [7:0] CMD_LOAD_ADDR   = 8'h55;
  localparam logic [7:0] CMD_UNIVERSAL   = 8'h56;
  localparam logic [7:0] CMD_PROG_PAGE   = 8'h64;
  localparam logic [7:0] CMD_READ_PAGE   = 8'h74;
  localparam logic [7:0] CMD_READ_SIGN   = 8'h75;
  localparam logic [7:0] SEL_MAJOR   = 8'h81;
  localparam logic [7:0] SEL_MINOR   = 8'h82;
  localparam logic [7:0] OP_EXT_ADDR = 8'h4D;
  localparam logic [7:0] DEST_EEPROM = 8'h45;
  localparam logic [7:0] HW_VERSION  = 8'h03;

  localparam logic [1:0] ACT_HOST = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_NEXT = 2'd2;
  localparam logic [1:0] ACT_DONE = 2'd3;

  localparam logic [1:0] FC_NONE  = 2'd0;
  localparam logic [1:0] FC_ERASE = 2'd1;
  localparam logic [1:0] FC_PROG  = 2'd2;
  localparam logic [1:0] FC_READ  = 2'd3;

  localparam logic [2:0] CFG_SIG0 = 3'd0;
  localparam logic [2:0] CFG_SIG1 = 3'd1;
  localparam logic [2:0] CFG_SIG2 = 3'd2;
  localparam logic [2:0] CFG_VMAJ = 3'd3;
  localparam logic [2:0] CFG_VMIN = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic [1:0]  flash_command;
    logic [23:0] flash_address;
    logic [15:0] flash_length;
    logic        page_byte_valid;
    logic [7:0]  page_byte;
    logic        reset_request;
    logic        halted;
    logic        last;
  } out_item_t;

  // one command's results, emitted in order by the output sequencer
  typedef struct packed {
    logic [2:0]  count;
    out_item_t [4:0] item;
  } burst_t;

  function automatic logic [4:0] operand_count(input logic [7:0] c);
    case (c)
      CMD_GET_PARAM:   operand_count = 5'd1;
      CMD_SET_DEV:     operand_count = 5'd20;
      CMD_SET_DEV_EXT: operand_count = 5'd5;
      CMD_LOAD_ADDR:   operand_count = 5'd4;
      CMD_UNIVERSAL:   operand_count = 5'd4;
      CMD_PROG_PAGE:   operand_count = 5'd5;
      CMD_READ_PAGE:   operand_count = 5'd5;
      default:         operand_count = 5'd0;
    endcase
  endfunction

  function automatic out_item_t mk_reply(input logic [7:0] b, input logic rr);
    out_item_t r;
    r = '0;
    r.reply_valid = 1'b1;
    r.reply_byte = b;
    r.reset_request = rr;
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/stk_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface stk_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/stk_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module stk_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/stk_seq.sv
// Output sequencer: emits a registered burst of up to 5 results one per ready cycle.
`default_nettype none
module stk_seq
  import stk_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  burst_t      burst,
  output logic        free_next,
  stk_if.source       out_ch
);
  burst_t     b_r;
  logic [2:0] idx_r;
  logic       pop;
  logic       busy;

  assign busy = (b_r.count != 3'd0);
  assign out_ch.valid = busy;
  assign out_ch.data = b_r.item[idx_r];
  assign pop = out_ch.valid && out_ch.ready;
  // free in next cycle if empty or popping the last item
  assign free_next = !busy || (pop && (idx_r + 3'd1 == b_r.count));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.count <= 3'd0;
      idx_r <= 3'd0;
    end else if (load) begin
      b_r <= burst;
      idx_r <= 3'd0;
    end else if (pop) begin
      if (idx_r + 3'd1 == b_r.count) begin
        b_r.count <= 3'd0;
        idx_r <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/stk500_flash_programming_engine.sv
// STK500 v1 command engine top level.
// Channels: in_ch carries {action, data_byte}; out_ch carries one result item
// (reply byte, flash command, page byte, flags, last). cfg_we/cfg_index/cfg_data
// write the signature and version registers.
// An accepted item is registered in the input stage, then parsed once the
// output burst register is free and any page RAM read is back; its results
// (zero to five) are loaded into the output burst register and shown one per
// ready cycle from the cycle after that, last marking the final one.
// A program-page byte request reads the page RAM (registered read) first, and
// its result loads only once that read data is available.
// Throughput: one item per cycle while the items give no result, the output
// burst register is free and no page RAM read is needed. The input register
// takes the next item while the previous burst drains, and parses it in the
// cycle that pops the last result of that burst.
// Reset (rst_n low, synchronous) returns to waiting for a command byte,
// clears the erase mask and halt flag and restores register defaults. Page
// RAM contents are not cleared. When the receiver stalls, the current result
// holds and the input stops accepting once the pending stage is full.
`default_nettype none
module stk500_flash_programming_engine
  import stk_pkg::*;
#(
  parameter int PageBytes = PageBytesDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  stk_if.sink             in_ch,
  stk_if.source           out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int AW = (PageBytes > 1) ? $clog2(PageBytes) : 1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_OPERANDS, PH_PAGE_DATA, PH_EOP, PH_WAIT_ERASE, PH_PROGRAM, PH_READ
  } phase_t;

  logic [7:0] sig0_r, sig1_r, sig2_r, vmaj_r, vmin_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [15:0] wa_r, wa_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] bri_r, bri_nxt;
  logic [7:0]  erased_r, erased_nxt;
  logic [7:0]  sel_r, sel_nxt;
  logic        halt_r, halt_nxt;

  in_item_t    it_r;
  logic        it_v_r;
  logic        rd_wait_r;     // page RAM read in flight
  burst_t      burst;
  logic        load;
  logic        seq_free;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  stk_ram #(.Width(8), .Depth(PageBytes)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(it_r.data_byte),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  stk_seq u_seq (
    .clk, .rst_n, .load, .burst, .free_next(seq_free), .out_ch
  );

  // a program-byte request that needs the RAM goes through a page RAM read first
  logic needs_read;
  assign needs_read = it_v_r && !halt_r && phase_r == PH_PROGRAM &&
                      it_r.action == ACT_NEXT && !rd_wait_r &&
                      bri_r < plen_r && {16'd0, bri_r} < 32'(PageBytes);
  assign ram_raddr = bri_r[AW-1:0];

  logic stage_go;   // item in stage is processed this cycle
  assign stage_go = it_v_r && !needs_read && seq_free;
  assign in_ch.ready = !it_v_r || stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r <= 1'b0;
      rd_wait_r <= 1'b0;
    end else begin
      rd_wait_r <= needs_read ? 1'b1 : (stage_go ? 1'b0 : rd_wait_r);
      if (in_ch.ready) it_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) it_r <= in_ch.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig0_r <= 8'h1E; sig1_r <= 8'h98; sig2_r <= 8'h01;
      vmaj_r <= 8'd6;  vmin_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIG0: sig0_r <= cfg_data;
        CFG_SIG1: sig1_r <= cfg_data;
        CFG_SIG2: sig2_r <= cfg_data;
        CFG_VMAJ: vmaj_r <= cfg_data;
        CFG_VMIN: vmin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [23:0] faddr(input logic [7:0] e, input logic [15:0] w);
    return {e, w[14:0], 1'b0};
  endfunction

  logic [7:0]  b;
  logic [15:0] pl_t;
  logic [4:0]  opc;
  always_comb begin
    phase_nxt = phase_r; cmd_nxt = cmd_r; fc_nxt = fc_r; wa_nxt = wa_r;
    ext_nxt = ext_r; plen_nxt = plen_r; bri_nxt = bri_r; erased_nxt = erased_r;
    sel_nxt = sel_r; halt_nxt = halt_r;
    burst = '0;
    ram_we = 1'b0;
    ram_waddr = fc_r[AW-1:0];
    b = it_r.data_byte;
    pl_t = plen_r;
    opc = operand_count(cmd_r);
    if (stage_go && !halt_r) begin
      case (phase_r)
        PH_IDLE: if (it_r.action == ACT_HOST) begin
          cmd_nxt = b;
          fc_nxt = '0;
          phase_nxt = (operand_count(b) != 5'd0) ? PH_OPERANDS : PH_EOP;
        end
        PH_OPERANDS: if (it_r.action == ACT_HOST) begin
          if (cmd_r == CMD_GET_PARAM) sel_nxt = b;
          else if (cmd_r == CMD_LOAD_ADDR) begin
            if (fc_r == 16'd0) wa_nxt = {8'd0, b};
            else if (fc_r == 16'd1) wa_nxt = wa_r | {8'd0, b};
            else wa_nxt = wa_r | {b, 8'd0};
            if (fc_r == 16'd3) ext_nxt = {ext_r[7:1], wa_nxt[15]};
          end else if (cmd_r == CMD_UNIVERSAL) begin
            if (fc_r == 16'd0) sel_nxt = b;
            else if (fc_r == 16'd2 && sel_r == OP_EXT_ADDR) ext_nxt = {b[6:0], ext_r[0]};
          end else if (cmd_r == CMD_PROG_PAGE || cmd_r == CMD_READ_PAGE) begin
            if (fc_r == 16'd0) pl_t = {b, 8'd0};
            else if (fc_r == 16'd1) pl_t = plen_r | {b, 8'd0};
            else if (fc_r <= 16'd3) pl_t = plen_r | {8'd0, b};
            else sel_nxt = b;
            plen_nxt = pl_t;
          end
          if (fc_r == 16'd3 && cmd_r == CMD_PROG_PAGE &&
              (pl_t == 16'd0 || {16'd0, pl_t} > 32'(PageBytes))) begin
            burst.count = 3'd1;
            burst.item[0] = mk_reply(ST_FAILED, 1'b1);
            halt_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            fc_nxt = fc_r + 16'd1;
            if (fc_nxt >= {11'd0, opc}) begin
              fc_nxt = '0;
              phase_nxt = (cmd_r == CMD_PROG_PAGE) ? PH_PAGE_DATA : PH_EOP;
            end
          end
        end
        PH_PAGE_DATA: if (it_r.action == ACT_HOST) begin
          ram_we = fc_r < plen_r && {16'd0, fc_r} < 32'(PageBytes);
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= plen_r) begin
            fc_nxt = '0;
            phase_nxt = PH_EOP;
          end
        end
        PH_EOP: if (it_r.action == ACT_HOST) begin
          phase_nxt = PH_IDLE;
          if (b != ST_EOP) begin
            burst.count = 3'd1;
            burst.item[0] = mk_reply(ST_FAILED, 1'b1);
            halt_nxt = 1'b1;
          end else begin
            case (cmd_r)
              CMD_GET_PARAM: begin
                burst.count = 3'd3;
                burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                burst.item[1] = mk_reply((sel_r == SEL_MINOR) ? vmin_r :
                                         (sel_r == SEL_MAJOR) ? vmaj_r : HW_VERSION, 1'b0);
                burst.item[2] = mk_reply(ST_OK, 1'b0);
              end
              CMD_UNIVERSAL: begin
                burst.count = 3'd3;
                burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                burst.item[1] = mk_reply(8'h00, 1'b0);
                burst.item[2] = mk_reply(ST_OK, 1'b0);
              end
              CMD_PROG_PAGE: begin
                burst.count = 3'd1;
                if (sel_r == DEST_EEPROM) begin
                  burst.item[0] = mk_reply(ST_FAILED, 1'b1);
                  halt_nxt = 1'b1;
                end else begin
                  burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                  burst.item[0].flash_address = faddr(ext_r, wa_r);
                  if (wa_r[14:0] == 15'd0 &&
                      (ext_r >= 8'd8 || !erased_r[ext_r[2:0]])) begin
                    if (ext_r < 8'd8) erased_nxt[ext_r[2:0]] = 1'b1;
                    burst.item[0].flash_command = FC_ERASE;
                    phase_nxt = PH_WAIT_ERASE;
                  end else begin
                    burst.item[0].flash_command = FC_PROG;
                    burst.item[0].flash_length = plen_r;
                    bri_nxt = '0;
                    phase_nxt = PH_PROGRAM;
                  end
                end
              end
              CMD_READ_PAGE: begin
                burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                burst.item[0].flash_command = FC_READ;
                burst.item[0].flash_address = faddr(ext_r, wa_r);
                burst.item[0].flash_length = plen_r;
                bri_nxt = '0;
                if (plen_r == 16'd0) begin
                  burst.count = 3'd2;
                  burst.item[1] = mk_reply(ST_OK, 1'b0);
                end else begin
                  burst.count = 3'd1;
                  phase_nxt = PH_READ;
                end
              end
              CMD_READ_SIGN: begin
                burst.count = 3'd5;
                burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                burst.item[1] = mk_reply(sig0_r, 1'b0);
                burst.item[2] = mk_reply(sig1_r, 1'b0);
                burst.item[3] = mk_reply(sig2_r, 1'b0);
                burst.item[4] = mk_reply(ST_OK, 1'b0);
              end
              CMD_LEAVE: begin
                burst.count = 3'd2;
                burst.item[0] = mk_reply(ST_INSYNC, 1'b1);
                burst.item[1] = mk_reply(ST_OK, 1'b1);
              end
              default: begin
                burst.count = 3'd2;
                burst.item[0] = mk_reply(ST_INSYNC, 1'b0);
                burst.item[1] = mk_reply(ST_OK, 1'b0);
              end
            endcase
          end
        end
        PH_WAIT_ERASE: if (it_r.action == ACT_DONE) begin
          burst.count = 3'd1;
          burst.item[0].flash_command = FC_PROG;
          burst.item[0].flash_address = faddr(ext_r, wa_r);
          burst.item[0].flash_length = plen_r;
          bri_nxt = '0;
          phase_nxt = PH_PROGRAM;
        end
        PH_PROGRAM: begin
          if (it_r.action == ACT_NEXT && rd_wait_r) begin
            burst.count = 3'd1;
            burst.item[0].page_byte_valid = 1'b1;
            burst.item[0].page_byte = ram_rdata;
            bri_nxt = bri_r + 16'd1;
          end else if (it_r.action == ACT_DONE) begin
            burst.count = 3'd1;
            burst.item[0] = mk_reply(ST_OK, 1'b0);
            phase_nxt = PH_IDLE;
          end
        end
        PH_READ: if (it_r.action == ACT_READ) begin
          burst.item[0] = mk_reply(b, 1'b0);
          bri_nxt = bri_r + 16'd1;
          if (bri_nxt >= plen_r) begin
            burst.count = 3'd2;
            burst.item[1] = mk_reply(ST_OK, 1'b0);
            phase_nxt = PH_IDLE;
          end else begin
            burst.count = 3'd1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
    for (int k = 0; k < 5; k++) begin
      burst.item[k].halted = halt_nxt;
      burst.item[k].last = (3'(k) + 3'd1 == burst.count);
    end
  end

  assign load = stage_go && burst.count != 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; cmd_r <= '0; fc_r <= '0; wa_r <= '0; ext_r <= '0;
      plen_r <= '0; bri_r <= '0; erased_r <= '0; sel_r <= '0; halt_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; cmd_r <= cmd_nxt; fc_r <= fc_nxt; wa_r <= wa_nxt;
      ext_r <= ext_nxt; plen_r <= plen_nxt; bri_r <= bri_nxt;
      erased_r <= erased_nxt; sel_r <= sel_nxt; halt_r <= halt_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/stk_checker.sv
// Port-level assertions for the STK500 engine, bound to the top level.
`default_nettype none
module stk_checker
  import stk_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.halted |-> out_data.last)
    else $error("result after halt");
  a_fail_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_valid && out_data.reply_byte == ST_FAILED &&
    out_data.reset_request |-> out_data.halted)
    else $error("failure without halt");
  a_page_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.page_byte_valid |->
    !out_data.reply_valid && out_data.flash_command == FC_NONE)
    else $error("page byte mixed with reply");
endmodule

bind stk500_flash_programming_engine stk_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the STK500 flash programming engine.
module tb;
  import stk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE, PH_OPERANDS, PH_PAGE_DATA, PH_EOP, PH_WAIT_ERASE, PH_PROGRAM, PH_READ
  } parse_phase_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] data;
    bit         typed;
    logic [7:0] last_reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  stk_if #(.T(in_item_t)) in_ch ();
  stk_if #(.T(out_item_t)) out_ch ();

  stk500_flash_programming_engine uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // engine model state
  parse_phase_t eng_phase;
  logic [7:0]  eng_cmd, eng_ext, eng_erased, eng_sel, ver_major, ver_minor;
  logic [15:0] eng_cnt, eng_waddr, eng_plen, eng_ridx;
  logic        eng_halt;
  logic [7:0]  page_mem [256];
  logic [7:0]  sig_reg [3];

  out_item_t step_results[$];
  out_item_t pending_results[$];
  logic [7:0] host_bytes[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int commands_sent = 0;
  bit hold_outputs = 1'b0;
  bit tx_no_gaps = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int num_operands(input logic [7:0] c);
    case (c)
      CMD_GET_PARAM: return 1;
      CMD_SET_DEV: return 20;
      CMD_SET_DEV_EXT: return 5;
      CMD_LOAD_ADDR: return 4;
      CMD_UNIVERSAL: return 4;
      CMD_PROG_PAGE: return 5;
      CMD_READ_PAGE: return 5;
      default: return 0;
    endcase
  endfunction

  function automatic void add_result(input logic rv, input logic [7:0] rb,
                                     input logic [1:0] fc, input logic [15:0] len,
                                     input logic pv, input logic [7:0] pb, input logic rr);
    out_item_t r;
    r = '0;
    r.reply_valid = rv;
    r.reply_byte = rb;
    r.flash_command = fc;
    if (fc != FC_NONE) r.flash_address = {eng_ext, eng_waddr[14:0], 1'b0};
    r.flash_length = len;
    r.page_byte_valid = pv;
    r.page_byte = pb;
    r.reset_request = rr;
    step_results.push_back(r);
  endfunction

  function automatic void halt_engine();
    add_result(1'b1, ST_FAILED, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b1);
    eng_halt = 1'b1;
    eng_phase = PH_IDLE;
  endfunction

  function automatic void start_program(input logic rv, input logic [7:0] rb);
    add_result(rv, rb, FC_PROG, eng_plen, 1'b0, 8'd0, 1'b0);
    eng_ridx = '0;
    eng_phase = PH_PROGRAM;
  endfunction

  function automatic void take_operand(input logic [7:0] b);
    int i;
    i = eng_cnt;
    case (eng_cmd)
      CMD_GET_PARAM: eng_sel = b;
      CMD_LOAD_ADDR: begin
        if (i == 0) eng_waddr = {8'h00, b};
        else if (i == 1) eng_waddr = eng_waddr | {8'h00, b};
        else eng_waddr = eng_waddr | {b, 8'h00};
        if (i == 3) eng_ext = eng_waddr[15] ? (eng_ext | 8'h01) : (eng_ext & 8'hFE);
      end
      CMD_UNIVERSAL: begin
        if (i == 0) eng_sel = b;
        else if (i == 2 && eng_sel == OP_EXT_ADDR) eng_ext = {b[6:0], eng_ext[0]};
      end
      CMD_PROG_PAGE, CMD_READ_PAGE: begin
        if (i == 0) eng_plen = {b, 8'h00};
        else if (i == 1) eng_plen = eng_plen | {b, 8'h00};
        else if (i <= 3) eng_plen = eng_plen | {8'h00, b};
        else eng_sel = b;
        if (i == 3 && eng_cmd == CMD_PROG_PAGE && (eng_plen < 1 || eng_plen > 256)) begin
          halt_engine();
          return;
        end
      end
      default: ;
    endcase
    eng_cnt++;
    if (eng_cnt >= num_operands(eng_cmd)) begin
      eng_cnt = '0;
      eng_phase = (eng_cmd == CMD_PROG_PAGE) ? PH_PAGE_DATA : PH_EOP;
    end
  endfunction

  function automatic void finish_packet(input logic [7:0] b);
    logic [7:0] v;
    eng_phase = PH_IDLE;
    if (b != ST_EOP) begin
      halt_engine();
      return;
    end
    case (eng_cmd)
      CMD_GET_PARAM: begin
        v = (eng_sel == SEL_MINOR) ? ver_minor : (eng_sel == SEL_MAJOR) ? ver_major : HW_VERSION;
        add_result(1'b1, ST_INSYNC, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, v, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
      end
      CMD_UNIVERSAL: begin
        add_result(1'b1, ST_INSYNC, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, 8'h00, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
      end
      CMD_PROG_PAGE: begin
        if (eng_sel == DEST_EEPROM) begin
          halt_engine();
          return;
        end
        if (eng_waddr[14:0] == 0 && (eng_ext >= 8 || !eng_erased[eng_ext[2:0]])) begin
          if (eng_ext < 8) eng_erased[eng_ext[2:0]] = 1'b1;
          add_result(1'b1, ST_INSYNC, FC_ERASE, 16'd0, 1'b0, 8'd0, 1'b0);
          eng_phase = PH_WAIT_ERASE;
        end else begin
          start_program(1'b1, ST_INSYNC);
        end
      end
      CMD_READ_PAGE: begin
        add_result(1'b1, ST_INSYNC, FC_READ, eng_plen, 1'b0, 8'd0, 1'b0);
        eng_ridx = '0;
        if (eng_plen == 0) add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        else eng_phase = PH_READ;
      end
      CMD_READ_SIGN: begin
        add_result(1'b1, ST_INSYNC, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        for (int k = 0; k < 3; k++)
          add_result(1'b1, sig_reg[k], FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
      end
      CMD_LEAVE: begin
        add_result(1'b1, ST_INSYNC, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b1);
        add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b1);
      end
      default: begin
        add_result(1'b1, ST_INSYNC, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
      end
    endcase
  endfunction

  // advance the engine model by one request and queue what it should produce
  function automatic void engine_step(input in_item_t it);
    step_results.delete();
    if (eng_halt) return;
    case (eng_phase)
      PH_IDLE: if (it.action == ACT_HOST) begin
        eng_cmd = it.data_byte;
        eng_cnt = '0;
        eng_phase = num_operands(it.data_byte) != 0 ? PH_OPERANDS : PH_EOP;
      end
      PH_OPERANDS: if (it.action == ACT_HOST) take_operand(it.data_byte);
      PH_PAGE_DATA: if (it.action == ACT_HOST) begin
        if (eng_cnt < eng_plen && eng_cnt < 256) page_mem[eng_cnt[7:0]] = it.data_byte;
        eng_cnt++;
        if (eng_cnt >= eng_plen) begin
          eng_cnt = '0;
          eng_phase = PH_EOP;
        end
      end
      PH_EOP: if (it.action == ACT_HOST) finish_packet(it.data_byte);
      PH_WAIT_ERASE: if (it.action == ACT_DONE) start_program(1'b0, 8'd0);
      PH_PROGRAM: begin
        if (it.action == ACT_NEXT) begin
          if (eng_ridx < eng_plen && eng_ridx < 256) begin
            add_result(1'b0, 8'd0, FC_NONE, 16'd0, 1'b1, page_mem[eng_ridx[7:0]], 1'b0);
            eng_ridx++;
          end
        end else if (it.action == ACT_DONE) begin
          add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
          eng_phase = PH_IDLE;
        end
      end
      PH_READ: if (it.action == ACT_READ) begin
        add_result(1'b1, it.data_byte, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
        eng_ridx++;
        if (eng_ridx >= eng_plen) begin
          add_result(1'b1, ST_OK, FC_NONE, 16'd0, 1'b0, 8'd0, 1'b0);
          eng_phase = PH_IDLE;
        end
      end
      default: eng_phase = PH_IDLE;
    endcase
    foreach (step_results[k]) begin
      step_results[k].halted = eng_halt;
      step_results[k].last = (k == step_results.size() - 1);
      pending_results.push_back(step_results[k]);
    end
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [7:0] b);
    int gap;
    in_item_t it;
    it.action = act;
    it.data_byte = b;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    engine_step(it);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_registers(input logic [7:0] v0, input logic [7:0] v1,
                                 input logic [7:0] v2, input logic [7:0] v3,
                                 input logic [7:0] v4);
    logic [7:0] vals [5];
    vals = '{v0, v1, v2, v3, v4};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      case (i[2:0])
        CFG_SIG0: sig_reg[0] = vals[i];
        CFG_SIG1: sig_reg[1] = vals[i];
        CFG_SIG2: sig_reg[2] = vals[i];
        CFG_VMAJ: ver_major = vals[i];
        CFG_VMIN: ver_minor = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void queue_random_command();
    logic [7:0] c, r1, r2, d;
    int len, pick;
    pick = $urandom_range(0, 9);
    commands_sent++;
    case (pick)
      0: begin
        host_bytes.push_back(CMD_GET_PARAM);
        case ($urandom_range(0, 2))
          0: host_bytes.push_back(SEL_MAJOR);
          1: host_bytes.push_back(SEL_MINOR);
          default: host_bytes.push_back(8'($urandom));
        endcase
      end
      1: begin
        host_bytes.push_back(CMD_SET_DEV);
        repeat (20) host_bytes.push_back(8'($urandom));
      end
      2: begin
        host_bytes.push_back(CMD_SET_DEV_EXT);
        repeat (5) host_bytes.push_back(8'($urandom));
      end
      3: begin
        host_bytes.push_back(CMD_LOAD_ADDR);
        if ($urandom_range(0, 1)) begin
          // block-aligned, so the next page may erase
          repeat (3) host_bytes.push_back(8'h00);
          host_bytes.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
        end else begin
          repeat (4) host_bytes.push_back(8'($urandom));
        end
      end
      4: begin
        host_bytes.push_back(CMD_UNIVERSAL);
        host_bytes.push_back($urandom_range(0, 2) != 0 ? OP_EXT_ADDR : 8'($urandom));
        host_bytes.push_back(8'($urandom));
        host_bytes.push_back(8'($urandom_range(0, 5)));
        host_bytes.push_back(8'($urandom));
      end
      5, 6: begin
        len = $urandom_range(1, 12);
        r1 = 8'($urandom);
        r2 = 8'($urandom);
        host_bytes.push_back(CMD_PROG_PAGE);
        host_bytes.push_back(8'(len >> 8) & r1);
        host_bytes.push_back(8'(len >> 8) & ~r1);
        host_bytes.push_back(8'(len) & r2);
        host_bytes.push_back(8'(len) & ~r2);
        d = 8'($urandom);
        if (d == DEST_EEPROM) d = 8'h46;
        host_bytes.push_back(d);
        repeat (len) host_bytes.push_back(8'($urandom));
      end
      7: begin
        len = $urandom_range(0, 6);
        r1 = 8'($urandom);
        host_bytes.push_back(CMD_READ_PAGE);
        host_bytes.push_back(8'h00);
        host_bytes.push_back(8'h00);
        host_bytes.push_back(8'(len) & r1);
        host_bytes.push_back(8'(len) & ~r1);
        host_bytes.push_back(8'($urandom));
      end
      8: host_bytes.push_back($urandom_range(0, 1) ? CMD_READ_SIGN : CMD_LEAVE);
      default: begin
        c = 8'($urandom);
        if (num_operands(c) != 0) c = 8'h30;
        host_bytes.push_back(c);
      end
    endcase
    host_bytes.push_back(ST_EOP);
  endfunction

  // act as host and flash for one request, steered by the model's phase
  task automatic drive_next_request();
    bit noise;
    noise = ($urandom_range(0, 9) == 0);
    case (eng_phase)
      PH_WAIT_ERASE:
        if (noise) send_request(2'($urandom_range(0, 2)), 8'($urandom));
        else send_request(ACT_DONE, 8'($urandom));
      PH_PROGRAM:
        if (noise) send_request(2'($urandom_range(0, 1)), 8'($urandom));
        else if (eng_ridx < eng_plen && $urandom_range(0, 29) != 0)
          send_request(ACT_NEXT, 8'($urandom));
        else if ($urandom_range(0, 3) == 0) send_request(ACT_NEXT, 8'($urandom));
        else send_request(ACT_DONE, 8'($urandom));
      PH_READ:
        if (noise) send_request($urandom_range(0, 1) ? ACT_HOST : ACT_NEXT, 8'($urandom));
        else send_request(ACT_READ, 8'($urandom));
      default:
        if (noise) begin
          send_request(2'($urandom_range(1, 3)), 8'($urandom));
        end else begin
          if (host_bytes.size() == 0) queue_random_command();
          send_request(ACT_HOST, host_bytes.pop_front());
        end
    endcase
  endtask

  task automatic run_random_phase(input int n_commands, input bit with_pressure);
    int start;
    bit held;
    start = commands_sent;
    held = 1'b0;
    while (commands_sent - start < n_commands || eng_phase != PH_IDLE || host_bytes.size() != 0)
    begin
      if ($urandom_range(0, 39) == 0) tx_no_gaps = !tx_no_gaps;
      if (with_pressure && commands_sent - start == 2 && !held) begin
        hold_outputs = 1'b1;
        held = 1'b1;
      end
      if (with_pressure && commands_sent - start == 4 && eng_phase == PH_IDLE
          && host_bytes.size() == 0) begin
        drain_results();
        queue_random_command();
      end
      drive_next_request();
    end
    drain_results();
  endtask

  dir_row_t dir_rows [19];

  initial begin
    int kind;
    logic [7:0] lb;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    eng_phase = PH_IDLE;
    {eng_cmd, eng_ext, eng_erased, eng_sel} = '0;
    {eng_cnt, eng_waddr, eng_plen, eng_ridx} = '0;
    eng_halt = 1'b0;
    sig_reg = '{8'h1E, 8'h98, 8'h01};
    ver_major = 8'd6;
    ver_minor = 8'd2;
    dir_rows = '{
      '{ACT_HOST, CMD_GET_PARAM, 0, 0}, '{ACT_HOST, SEL_MAJOR, 0, 0},
      '{ACT_HOST, ST_EOP, 1, ST_OK},
      '{ACT_HOST, CMD_READ_SIGN, 0, 0}, '{ACT_HOST, ST_EOP, 1, ST_OK},
      '{ACT_HOST, CMD_LEAVE, 0, 0}, '{ACT_HOST, ST_EOP, 1, ST_OK},
      '{ACT_HOST, CMD_UNIVERSAL, 0, 0}, '{ACT_HOST, OP_EXT_ADDR, 0, 0},
      '{ACT_HOST, 8'h00, 0, 0}, '{ACT_HOST, 8'h7F, 0, 0}, '{ACT_HOST, 8'h00, 0, 0},
      '{ACT_HOST, ST_EOP, 1, ST_OK},
      '{ACT_HOST, CMD_LOAD_ADDR, 0, 0}, '{ACT_HOST, 8'hFF, 0, 0},
      '{ACT_HOST, 8'hFF, 0, 0}, '{ACT_HOST, 8'hFF, 0, 0}, '{ACT_HOST, 8'hFF, 0, 0},
      '{ACT_HOST, ST_EOP, 1, ST_OK}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].act, dir_rows[i].data);
      if (dir_rows[i].typed && (step_results.size() == 0 ||
          step_results[$].reply_byte != dir_rows[i].last_reply))
        report_mismatch($sformatf("directed row %0d: final reply not %02h", i,
                                  dir_rows[i].last_reply));
    end
    drain_results();

    run_random_phase(6, 1'b0);
    write_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_random_phase(6, 1'b1);
    write_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random_phase(5, 1'b0);
    write_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
    run_random_phase(4, 1'b0);

    // end on one of the halting errors, then show that input is ignored
    kind = $urandom_range(0, 2);
    case (kind)
      0: begin
        send_request(ACT_HOST, CMD_READ_SIGN);
        send_request(ACT_HOST, 8'($urandom_range(0, 31)));
      end
      1: begin
        send_request(ACT_HOST, CMD_PROG_PAGE);
        send_request(ACT_HOST, 8'h00);
        send_request(ACT_HOST, 8'h00);
        send_request(ACT_HOST, 8'h00);
        send_request(ACT_HOST, 8'h01);
        send_request(ACT_HOST, DEST_EEPROM);
        send_request(ACT_HOST, 8'($urandom));
        send_request(ACT_HOST, ST_EOP);
      end
      default: begin
        // length of zero or one byte past a full page
        lb = $urandom_range(0, 1) ? 8'h01 : 8'h00;
        send_request(ACT_HOST, CMD_PROG_PAGE);
        send_request(ACT_HOST, lb);
        send_request(ACT_HOST, 8'h00);
        send_request(ACT_HOST, lb);
        send_request(ACT_HOST, 8'h00);
      end
    endcase
    if (step_results.size() == 0 || step_results[$].reply_byte != ST_FAILED)
      report_mismatch("halting error: final reply not FAILED");
    repeat (6) send_request(2'($urandom_range(0, 3)), 8'($urandom));
    drain_results();
    repeat (20) @(posedge clk);

    $display("Run covered %0d requests, %0d random commands, %0d results checked,",
             requests_sent, commands_sent, results_checked);
    $display("three register settings and a final halting error; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // result side: random stalls, one long hold-off, compare against the oldest expectation
  initial begin
    int stall;
    bit rx_no_stalls;
    out_item_t got, want;
    rx_no_stalls = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_no_stalls = !rx_no_stalls;
      stall = rx_no_stalls ? 0 : $urandom_range(0, 16);
      if (hold_outputs) begin
        stall = 300;
        hold_outputs = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.data;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        want = pending_results.pop_front();
        check_field("reply_valid", got.reply_valid, want.reply_valid);
        check_field("reply_byte", got.reply_byte, want.reply_byte);
        check_field("flash_command", got.flash_command, want.flash_command);
        check_field("flash_address", got.flash_address, want.flash_address);
        check_field("flash_length", got.flash_length, want.flash_length);
        check_field("page_byte_valid", got.page_byte_valid, want.page_byte_valid);
        check_field("page_byte", got.page_byte, want.page_byte);
        check_field("reset_request", got.reset_request, want.reset_request);
        check_field("halted", got.halted, want.halted);
        check_field("last", got.last, want.last);
      end
    end
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
rtl/stk_pkg.sv
rtl/stk_if.sv
rtl/stk_ram.sv
rtl/stk_seq.sv
rtl/stk500_flash_programming_engine.sv
rtl/stk_checker.sv
tb/tb.sv
